>>> src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stuffed frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LEN_W     = 13;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned MAX_PAYLOAD_DEF = 4096;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FLAG        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STUFF_FLAG  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STUFF_ESC   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INFO_SEQ0   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INFO_SEQ1   = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [BYTE_W-1:0] FLAG_RST       = 8'h7E;
	localparam logic [BYTE_W-1:0] ESCAPE_RST     = 8'h7D;
	localparam logic [BYTE_W-1:0] STUFF_FLAG_RST = 8'h5E;
	localparam logic [BYTE_W-1:0] STUFF_ESC_RST  = 8'h5D;
	localparam logic [BYTE_W-1:0] ADDRESS_RST    = 8'h03;
	localparam logic [BYTE_W-1:0] INFO_SEQ0_RST  = 8'h00;
	localparam logic [BYTE_W-1:0] INFO_SEQ1_RST  = 8'h40;

	// Verdict codes.
	localparam logic [STATUS_W-1:0] STAT_NEW      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DUP      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_CHECK    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_ESC  = 2'd3;

	// Result kinds.
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] flag_code;
		logic [BYTE_W-1:0] escape_code;
		logic [BYTE_W-1:0] stuffed_flag_code;
		logic [BYTE_W-1:0] stuffed_escape_code;
		logic [BYTE_W-1:0] address_code;
		logic [BYTE_W-1:0] info_seq0_code;
		logic [BYTE_W-1:0] info_seq1_code;
	} cfg_t;

	typedef struct packed {
		logic                result_kind;
		logic [BYTE_W-1:0]   data_byte;
		logic [STATUS_W-1:0] frame_status;
		logic [LEN_W-1:0]    payload_length;
		logic                frame_seq;
		logic                send_reply;
		logic                reply_is_reject;
		logic                reply_seq;
	} res_t;

	typedef enum logic [5:0] {
		ST_HUNT = 6'b000001,
		ST_FLAG = 6'b000010,
		ST_ADDR = 6'b000100,
		ST_CTRL = 6'b001000,
		ST_DATA = 6'b010000,
		ST_ESC  = 6'b100000
	} parse_state_t;

endpackage

>>> src/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration register file written through the valid/ready write port.
// ----------------------------------------------------------------------------
module sfr_cfg_regs
	import sfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_code           <= FLAG_RST;
			cfg_q.escape_code         <= ESCAPE_RST;
			cfg_q.stuffed_flag_code   <= STUFF_FLAG_RST;
			cfg_q.stuffed_escape_code <= STUFF_ESC_RST;
			cfg_q.address_code        <= ADDRESS_RST;
			cfg_q.info_seq0_code      <= INFO_SEQ0_RST;
			cfg_q.info_seq1_code      <= INFO_SEQ1_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FLAG:       cfg_q.flag_code           <= cfg_data;
				REG_ESCAPE:     cfg_q.escape_code         <= cfg_data;
				REG_STUFF_FLAG: cfg_q.stuffed_flag_code   <= cfg_data;
				REG_STUFF_ESC:  cfg_q.stuffed_escape_code <= cfg_data;
				REG_ADDRESS:    cfg_q.address_code        <= cfg_data;
				REG_INFO_SEQ0:  cfg_q.info_seq0_code      <= cfg_data;
				REG_INFO_SEQ1:  cfg_q.info_seq1_code      <= cfg_data;
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser
// Input register and frame parser: header match, destuffing, data check,
// one-byte-late payload emission and end-of-frame verdict.
// ----------------------------------------------------------------------------
module sfr_parser
	import sfr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              out_free,
	output logic              res_valid,
	output res_t              res
);

	localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 2);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_PAYLOAD + 1);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;

	parse_state_t      state_q, state_d;
	logic              fseq_q, fseq_d;
	logic              exp_seq_q, exp_seq_d;
	logic [BYTE_W-1:0] check_q, check_d;
	logic [BYTE_W-1:0] held_q, held_d;
	logic              held_valid_q, held_valid_d;
	logic [CNT_W-1:0]  count_q, count_d;

	logic              take;
	logic [BYTE_W-1:0] take_byte;
	logic [BYTE_W-1:0] ctrl_code;
	logic [CNT_W-1:0]  len_full;
	logic              has_res;
	res_t              res_d;

	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign ctrl_code = fseq_q ? cfg.info_seq1_code : cfg.info_seq0_code;
	assign len_full  = (count_q == '0) ? '0 : count_q - CNT_W'(1);

	always_comb begin
		state_d      = state_q;
		fseq_d       = fseq_q;
		exp_seq_d    = exp_seq_q;
		check_d      = check_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		count_d      = count_q;
		take         = 1'b0;
		take_byte    = byte_s1;
		has_res      = 1'b0;
		res_d        = '0;

		unique case (state_q)
			ST_HUNT: begin
				if (byte_s1 == cfg.flag_code) begin
					state_d = ST_FLAG;
				end
			end
			ST_FLAG: begin
				if (byte_s1 == cfg.address_code) begin
					state_d = ST_ADDR;
				end else if (byte_s1 != cfg.flag_code) begin
					state_d = ST_HUNT;
				end
			end
			ST_ADDR: begin
				if (byte_s1 == cfg.info_seq0_code) begin
					fseq_d  = 1'b0;
					state_d = ST_CTRL;
				end else if (byte_s1 == cfg.info_seq1_code) begin
					fseq_d  = 1'b1;
					state_d = ST_CTRL;
				end else if (byte_s1 == cfg.flag_code) begin
					state_d = ST_FLAG;
				end else begin
					state_d = ST_HUNT;
				end
			end
			ST_CTRL: begin
				if (byte_s1 == (cfg.address_code ^ ctrl_code)) begin
					state_d      = ST_DATA;
					check_d      = '0;
					held_valid_d = 1'b0;
					held_d       = '0;
					count_d      = '0;
				end else if (byte_s1 == cfg.flag_code) begin
					state_d = ST_FLAG;
				end else begin
					state_d = ST_HUNT;
				end
			end
			ST_DATA: begin
				if (byte_s1 == cfg.flag_code) begin
					// Closing flag: the held byte is the data check byte and is dropped.
					has_res             = 1'b1;
					res_d.result_kind   = KIND_VERDICT;
					res_d.frame_seq     = fseq_q;
					res_d.send_reply    = 1'b1;
					if (check_q == '0) begin
						res_d.reply_seq = ~fseq_q;
						if (fseq_q == exp_seq_q) begin
							res_d.frame_status   = STAT_NEW;
							res_d.payload_length = LEN_W'(len_full);
							exp_seq_d            = ~exp_seq_q;
						end else begin
							res_d.frame_status = STAT_DUP;
						end
					end else begin
						res_d.frame_status    = STAT_CHECK;
						res_d.reply_is_reject = 1'b1;
						res_d.reply_seq       = fseq_q;
					end
					held_valid_d = 1'b0;
					state_d      = ST_HUNT;
				end else if (byte_s1 == cfg.escape_code) begin
					state_d = ST_ESC;
				end else begin
					take = 1'b1;
				end
			end
			ST_ESC: begin
				// The flag meaning wins when both stuffed codes are equal.
				if (byte_s1 == cfg.stuffed_flag_code) begin
					state_d   = ST_DATA;
					take      = 1'b1;
					take_byte = cfg.flag_code;
				end else if (byte_s1 == cfg.stuffed_escape_code) begin
					state_d   = ST_DATA;
					take      = 1'b1;
					take_byte = cfg.escape_code;
				end else begin
					has_res            = 1'b1;
					res_d.result_kind  = KIND_VERDICT;
					res_d.frame_status = STAT_BAD_ESC;
					res_d.frame_seq    = fseq_q;
					held_valid_d       = 1'b0;
					state_d            = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase

		if (take) begin
			check_d      = check_q ^ take_byte;
			held_d       = take_byte;
			held_valid_d = 1'b1;
			if (count_q < CNT_SAT) begin
				count_d = count_q + CNT_W'(1);
			end
			if (held_valid_q) begin
				has_res           = 1'b1;
				res_d.result_kind = KIND_DATA;
				res_d.data_byte   = held_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_HUNT;
			fseq_q       <= 1'b0;
			exp_seq_q    <= 1'b0;
			check_q      <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			count_q      <= '0;
		end else if (advance) begin
			state_q      <= state_d;
			fseq_q       <= fseq_d;
			exp_seq_q    <= exp_seq_d;
			check_q      <= check_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			count_q      <= count_d;
		end
	end

	assign res_valid = advance && has_res;
	assign res       = res_d;

endmodule

>>> src/sfr_out_reg.sv
// ----------------------------------------------------------------------------
// sfr_out_reg
// Result register between the parser and the output channel.
// ----------------------------------------------------------------------------
module sfr_out_reg
	import sfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res,
	output logic out_free,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

>>> src/stuffed_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_top
// Stop-and-wait receiver for flag-delimited, byte-stuffed information frames.
// ----------------------------------------------------------------------------
// The receiver takes one raw link byte per item and can take a new item in
// every clock cycle while input stall is low. Each byte passes through an
// input register, is parsed by the frame state machine and, when it yields a
// result, lands in the output register, from which it is presented to the
// consumer. Payload bytes come out one byte late, so the trailing check byte
// is never delivered; the closing flag yields a verdict item with the reply
// to send. Input stall rises only while the output register holds a result
// that the consumer has not taken and the input register is full.
// Configuration writes are always ready and take effect on the next byte.
module stuffed_frame_receiver_top
	import sfr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 result_kind,
	output logic [BYTE_W-1:0]    data_byte,
	output logic [STATUS_W-1:0]  frame_status,
	output logic [LEN_W-1:0]     payload_length,
	output logic                 frame_seq,
	output logic                 send_reply,
	output logic                 reply_is_reject,
	output logic                 reply_seq,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	cfg_t cfg;
	res_t res;
	res_t out_res;
	logic res_valid;
	logic out_free;

	assign cfg_ready = 1'b1;

	sfr_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfr_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	sfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign result_kind     = out_res.result_kind;
	assign data_byte       = out_res.data_byte;
	assign frame_status    = out_res.frame_status;
	assign payload_length  = out_res.payload_length;
	assign frame_seq       = out_res.frame_seq;
	assign send_reply      = out_res.send_reply;
	assign reply_is_reject = out_res.reply_is_reject;
	assign reply_seq       = out_res.reply_seq;

endmodule
